FILE: rtl/directional_integer_sorter_assert.svh
`ifndef DIRECTIONAL_INTEGER_SORTER_ASSERT_SVH
`define DIRECTIONAL_INTEGER_SORTER_ASSERT_SVH

`ifndef ASSERT_OFF

`define DIS_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");

`define DIS_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");

`else

`define DIS_ASSERT_IMP(label, clk, rst_n, a, b)

`define DIS_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

FILE: rtl/dis_pkg.sv
`timescale 1ns / 1ps

package dis_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic REG_SORT_DESC = 1'b0;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_UP,
    CELL_DOWN
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

FILE: rtl/dis_cell.sv
`timescale 1ns / 1ps

module dis_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dis_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [dis_pkg::DATA_W-1:0]  lo_value_i,
  input  logic                               lo_valid_i,
  input  logic                               lo_lt_i,
  input  logic signed [dis_pkg::DATA_W-1:0]  hi_value_i,
  input  logic                               hi_valid_i,
  output logic signed [dis_pkg::DATA_W-1:0]  value_o,
  output logic                               valid_o,
  output logic                               lt_o
);

  logic signed [dis_pkg::DATA_W-1:0] value_q, value_d;
  logic                              valid_q, valid_d;

  assign lt_o = !valid_q || (ctrl_i.value < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    unique case (ctrl_i.op)
      dis_pkg::CELL_HOLD: begin
      end
      dis_pkg::CELL_INSERT: begin
        if (lo_lt_i) begin
          value_d = lo_value_i;
          valid_d = lo_valid_i;
        end else if (lt_o) begin
          value_d = ctrl_i.value;
          valid_d = 1'b1;
        end
      end
      dis_pkg::CELL_UP: begin
        value_d = lo_value_i;
        valid_d = lo_valid_i;
      end
      dis_pkg::CELL_DOWN: begin
        value_d = hi_value_i;
        valid_d = hi_valid_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

FILE: rtl/directional_integer_sorter.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_ready_o   value_i, last_item_i
// out       out  out_valid_o / out_ready_i sorted_value_o, last_result_o, overflow_o
// apb       in   psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// Fill: one value per cycle, inserted in order into a chain of MAX_ITEMS cells.
// Drain: smallest first emits one value per cycle from the bottom cell; largest
// first first shifts the chain up until the top cell holds a value, then one per cycle.
// No input is taken while a block drains; a waiting result holds the chain.
// Reset clears all cell valid bits, the count, the overflow flag and the register.

`include "directional_integer_sorter_assert.svh"

module directional_integer_sorter #(
  parameter int unsigned MAX_ITEMS = dis_pkg::MAX_ITEMS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [dis_pkg::DATA_W-1:0]  value_i,
  input  logic                               last_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [dis_pkg::DATA_W-1:0]  sorted_value_o,
  output logic                               last_result_o,
  output logic                               overflow_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dis_pkg::APB_AW-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] remain_q;
  logic             ovf_seen_q;
  logic             ovf_out_q;
  logic             dir_q;
  logic             sort_descending_q;

  logic                              in_fire;
  logic                              out_fire;
  logic                              full;
  logic                              reg_hit;
  dis_pkg::cell_ctrl_t               ctrl;
  logic signed [dis_pkg::DATA_W-1:0] cell_value [MAX_ITEMS];
  logic                              cell_valid [MAX_ITEMS];
  logic                              cell_lt    [MAX_ITEMS];

  assign pready  = 1'b1;
  assign reg_hit = (paddr[dis_pkg::APB_AW-1:2] == dis_pkg::REG_SORT_DESC);
  assign prdata  = reg_hit ? {31'b0, sort_descending_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_descending_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sort_descending_q <= pwdata[0];
    end
  end

  assign full        = (count_q == CNT_MAX);
  assign in_ready_o  = (state_q == ST_FILL);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_DRAIN) &&
                       (dir_q ? cell_valid[MAX_ITEMS-1] : cell_valid[0]);
  assign out_fire    = out_valid_o && out_ready_i;

  assign sorted_value_o = dir_q ? cell_value[MAX_ITEMS-1] : cell_value[0];
  assign last_result_o  = (remain_q == CNT_ONE);
  assign overflow_o     = ovf_out_q;

  always_comb begin
    ctrl.value = value_i;
    ctrl.op    = dis_pkg::CELL_HOLD;
    if (state_q == ST_FILL) begin
      if (in_fire && !full) begin
        ctrl.op = dis_pkg::CELL_INSERT;
      end
    end else if (dir_q) begin
      if (!cell_valid[MAX_ITEMS-1] || out_ready_i) begin
        ctrl.op = dis_pkg::CELL_UP;
      end
    end else if (out_fire) begin
      ctrl.op = dis_pkg::CELL_DOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      count_q    <= '0;
      remain_q   <= '0;
      ovf_seen_q <= 1'b0;
      ovf_out_q  <= 1'b0;
      dir_q      <= 1'b0;
    end else begin
      unique case (state_q)
        ST_FILL: begin
          if (in_fire) begin
            if (last_item_i) begin
              state_q    <= ST_DRAIN;
              remain_q   <= full ? count_q : count_q + CNT_ONE;
              ovf_out_q  <= ovf_seen_q || full;
              dir_q      <= sort_descending_q;
              count_q    <= '0;
              ovf_seen_q <= 1'b0;
            end else if (full) begin
              ovf_seen_q <= 1'b1;
            end else begin
              count_q <= count_q + CNT_ONE;
            end
          end
        end
        ST_DRAIN: begin
          if (out_fire) begin
            remain_q <= remain_q - CNT_ONE;
            if (remain_q == CNT_ONE) begin
              state_q <= ST_FILL;
            end
          end
        end
      endcase
    end
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    logic signed [dis_pkg::DATA_W-1:0] lo_value;
    logic                              lo_valid;
    logic                              lo_lt;
    logic signed [dis_pkg::DATA_W-1:0] hi_value;
    logic                              hi_valid;

    if (g == 0) begin : g_bottom
      assign lo_value = '0;
      assign lo_valid = 1'b0;
      assign lo_lt    = 1'b0;
    end else begin : g_lower
      assign lo_value = cell_value[g-1];
      assign lo_valid = cell_valid[g-1];
      assign lo_lt    = cell_lt[g-1];
    end

    if (g == MAX_ITEMS - 1) begin : g_top
      assign hi_value = '0;
      assign hi_valid = 1'b0;
    end else begin : g_upper
      assign hi_value = cell_value[g+1];
      assign hi_valid = cell_valid[g+1];
    end

    dis_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .lo_value_i (lo_value),
      .lo_valid_i (lo_valid),
      .lo_lt_i    (lo_lt),
      .hi_value_i (hi_value),
      .hi_valid_i (hi_valid),
      .value_o    (cell_value[g]),
      .valid_o    (cell_valid[g]),
      .lt_o       (cell_lt[g])
    );
  end

  `DIS_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `DIS_ASSERT_NEXT(a_last_in_drains, clk_i, rst_ni, in_fire && last_item_i, !in_ready_o)
  `DIS_ASSERT_NEXT(a_last_out_fills, clk_i, rst_ni, out_fire && last_result_o, in_ready_o)
  `DIS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, in_ready_o, count_q <= CNT_MAX)

endmodule
